// ===== rtl/ostt_pkg.sv =====
// ----------------------------------------------------------------------------
// ostt_pkg
// Shared types and codes of the one-shot timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package ostt_pkg;

    // opcodes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;

    // command queue between front and back, depth is a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  action_id;
        logic [15:0] delay;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fired_action;
        logic       last;
    } t_out_item;

    // classified command handed to the back end
    typedef struct packed {
        logic        is_tick;
        logic [7:0]  action;
        logic [15:0] delay;
    } t_cmd;

    // one table entry
    typedef struct packed {
        logic [7:0]  action;
        logic [15:0] countdown;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/ostt_front.sv =====
// ----------------------------------------------------------------------------
// ostt_front
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_front import ostt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_cmd_vld,
    output t_cmd          o_cmd,
    input  wire logic     i_cmd_pop
);

    t_cmd              r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_fill;
    logic              w_push;
    logic              w_pop;
    t_cmd              w_cmd;

    assign o_stall   = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_cmd_pop && o_cmd_vld;
    assign o_cmd_vld = (r_fill != '0);
    assign o_cmd     = r_q[r_rp];

    // classify the raw item
    always_comb begin
        w_cmd.is_tick = (i_item.opcode == OP_TICK);
        w_cmd.action  = i_item.action_id;
        w_cmd.delay   = i_item.delay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!w_push && w_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ostt_engine.sv =====
// ----------------------------------------------------------------------------
// ostt_engine
// Timer table memory, start handling and the per-tick scan sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_engine import ostt_pkg::*; #(
    parameter int MAX_TIMERS = 16,
    parameter int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1,
    parameter int CNT_W      = $clog2(MAX_TIMERS + 1)
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_vld,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_item       o_item,
    output logic [CNT_W-1:0] o_count,
    output logic            o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RD    = 2'd1;
    localparam logic [1:0] S_EV    = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TIMERS);

    t_entry            r_mem [MAX_TIMERS];
    t_entry            r_rd_k;
    t_entry            r_rd_top;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [IDX_W-1:0]  r_k,     n_k;
    logic              r_pend_vld, n_pend_vld;
    logic [7:0]        r_pend_act, n_pend_act;
    logic              r_out_vld;
    t_out_item         r_out;

    logic [CNT_W-1:0]  w_top_cnt;
    logic [IDX_W-1:0]  w_top;
    logic [15:0]       w_dec;
    logic              w_out_free;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;
    logic              w_load;
    t_out_item         w_load_item;
    logic              w_advance;

    assign w_top_cnt  = r_cnt - 1'b1;
    assign w_top      = w_top_cnt[IDX_W-1:0];
    assign w_dec      = r_rd_k.countdown - 16'd1;
    assign w_out_free = !r_out_vld || !i_stall;

    assign o_valid = r_out_vld;
    assign o_item  = r_out;
    assign o_count = r_cnt;
    assign o_busy  = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_pend_vld  = r_pend_vld;
        n_pend_act  = r_pend_act;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_k;
        w_wdata     = r_rd_k;
        w_load      = 1'b0;
        w_load_item = '0;
        w_advance   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    if (!i_cmd.is_tick) begin
                        if (w_out_free) begin
                            o_cmd_pop                = 1'b1;
                            w_load                   = 1'b1;
                            w_load_item.fired_action = i_cmd.action;
                            w_load_item.last         = 1'b1;
                            if (r_cnt != CNT_MAX) begin
                                w_we              = 1'b1;
                                w_waddr           = r_cnt[IDX_W-1:0];
                                w_wdata.action    = i_cmd.action;
                                w_wdata.countdown = i_cmd.delay;
                                n_cnt             = r_cnt + 1'b1;
                                w_load_item.kind  = KIND_ACCEPTED;
                            end else begin
                                w_load_item.kind  = KIND_REJECTED;
                            end
                        end
                    end else begin
                        // tick on an empty table is dropped
                        o_cmd_pop = 1'b1;
                        if (r_cnt != '0) begin
                            n_k        = w_top;
                            n_pend_vld = 1'b0;
                            n_state    = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (w_dec != 16'd0) begin
                    w_we              = 1'b1;
                    w_wdata.countdown = w_dec;
                    w_advance         = 1'b1;
                end else if (!r_pend_vld || w_out_free) begin
                    // expired: previous pending fire goes out, this one waits
                    if (r_pend_vld) begin
                        w_load                   = 1'b1;
                        w_load_item.kind         = KIND_FIRED;
                        w_load_item.fired_action = r_pend_act;
                        w_load_item.last         = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_act = r_rd_k.action;
                    if (r_k != w_top) begin
                        w_we    = 1'b1;
                        w_wdata = r_rd_top;
                    end
                    n_cnt     = w_top_cnt;
                    w_advance = 1'b1;
                end
                if (w_advance) begin
                    if (r_k == '0) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_load                   = 1'b1;
                    w_load_item.kind         = KIND_FIRED;
                    w_load_item.fired_action = r_pend_act;
                    w_load_item.last         = 1'b1;
                    n_pend_vld               = 1'b0;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_k        <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_k        <= n_k;
            r_pend_vld <= n_pend_vld;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_act <= n_pend_act;
        if (w_load) begin
            r_out <= w_load_item;
        end
    end

    // table memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_RD) begin
            r_rd_k   <= r_mem[r_k];
            r_rd_top <= r_mem[w_top];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/one_shot_timer_table.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_table
// Unsorted table of one-shot timers with start and tick items.
// ----------------------------------------------------------------------------
// A start item is handled in the idle state once it leaves the input queue,
// waits while the output is stalled, and always yields one item (accepted,
// or rejected when all MAX_TIMERS slots are in use). A tick item walks the
// active entries from newest to oldest; each entry takes a registered read
// of the table memory, then the decrement, compare and write back through
// its single write port, and an expired entry waits while a pending fired
// item cannot go out. Each expired entry gives one fired item and is replaced
// by the newest entry; the last fired item of a tick carries last. Ticks on
// an empty table and ticks that fire nothing give no item. A two-entry queue
// at the input accepts items while the engine scans or the output is
// stalled, until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_table import ostt_pkg::*; #(
    parameter int MAX_TIMERS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_item
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    // queue to engine
    logic             w_cmd_vld;
    t_cmd             w_cmd;
    logic             w_cmd_pop;

    // engine status
    logic [CNT_W-1:0] w_count;
    logic             w_busy;

    // front: accept and classify items into the command queue
    ostt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_cmd_vld (w_cmd_vld),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    // back: table memory, start insert and tick scan
    ostt_engine #(
        .MAX_TIMERS (MAX_TIMERS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item),
        .o_count   (w_count),
        .o_busy    (w_busy)
    );

    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(MAX_TIMERS))
        else $error("timer count above capacity");

    // start results are always the only item of their input
    a_start_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind != KIND_FIRED) |-> o_item.last)
        else $error("start result without last");

    // count grows by at most one per cycle and only from idle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (w_count > $past(w_count)))
            |-> (w_count == $past(w_count) + 1'b1) && !$past(w_busy))
        else $error("bad count increment");

    // count drops only during a tick scan
    a_count_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (w_count < $past(w_count))) |-> $past(w_busy))
        else $error("count dropped outside a scan");

endmodule

`default_nettype wire
